@@ hdl/necir_pkg.sv @@
// shared types and constants of the nec infrared pulse-distance decoder
package necir_pkg;

    localparam int unsigned TOL_W    = 10;
    localparam int unsigned PER_W    = 15;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned CNT_W    = 8;

    localparam logic [PER_W-1:0] NOM_ZERO   = 15'd1125;
    localparam logic [PER_W-1:0] NOM_ONE    = 15'd2250;
    localparam logic [PER_W-1:0] NOM_REPEAT = 15'd11250;
    localparam logic [PER_W-1:0] NOM_START  = 15'd13500;

    localparam logic [0:0] REG_TOLERANCE = 1'b0;
    localparam logic [TOL_W-1:0] TOL_RESET = 10'd200;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_ZERO   = 3'd1,
        CLS_ONE    = 3'd2,
        CLS_REPEAT = 3'd3,
        CLS_START  = 3'd4
    } class_t;

    typedef struct packed {
        logic        decoded;
        logic        repeat_seen;
        logic [31:0] packet;
    } result_t;

endpackage

@@ hdl/necir_front.sv @@
// front part: edge period measurement and classification
module necir_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [31:0]                   edge_time_us,
    input  logic [necir_pkg::TOL_W-1:0]   tolerance,
    output necir_pkg::class_t             cls
);
    import necir_pkg::*;

    logic [31:0]      prev_time_reg;
    logic [31:0]      period;
    logic [PER_W-1:0] per;
    logic [PER_W-1:0] tol;
    logic             short_enough;

    function automatic logic in_win(input logic [PER_W-1:0] p,
                                    input logic [PER_W-1:0] nom,
                                    input logic [PER_W-1:0] t);
        return (p >= nom - t) && (p <= nom + t);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
        end
        else if (accept)
        begin
            prev_time_reg <= edge_time_us;
        end
    end

    // every window tops out below 2^15, so longer periods never match
    assign period       = edge_time_us - prev_time_reg;
    assign per          = period[PER_W-1:0];
    assign short_enough = (period[31:PER_W] == '0);
    assign tol          = {{(PER_W-TOL_W){1'b0}}, tolerance};

    always_comb
    begin
        cls = CLS_NONE;
        if (short_enough)
        begin
            if (in_win(per, NOM_ZERO, tol))
                cls = CLS_ZERO;
            else if (in_win(per, NOM_ONE, tol))
                cls = CLS_ONE;
            else if (in_win(per, NOM_REPEAT, tol))
                cls = CLS_REPEAT;
            else if (in_win(per, NOM_START, tol))
                cls = CLS_START;
        end
    end

endmodule

@@ hdl/necir_fifo.sv @@
// two-entry queue of edge classes between front and back
module necir_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  necir_pkg::class_t push_cls,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output necir_pkg::class_t pop_cls
);
    import necir_pkg::*;

    class_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cls;
    end

    assign full      = count_reg[1];
    assign not_empty = (count_reg != 2'd0);
    assign pop_cls   = mem_reg[rd_ptr_reg];

endmodule

@@ hdl/necir_back.sv @@
// back part: shift register, bit count, packet commit and result register
module necir_back #(
    parameter int unsigned PACKET_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cls_valid,
    input  necir_pkg::class_t   cls,
    output logic                cls_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output necir_pkg::result_t  result
);
    import necir_pkg::*;

    localparam logic [CNT_W-1:0] RELOAD = CNT_W'(PACKET_BITS);

    logic [31:0]      shift_reg;
    logic [31:0]      shift_next;
    logic [CNT_W-1:0] bits_reg;
    logic [CNT_W-1:0] bits_next;
    logic [31:0]      packet_reg;
    logic [31:0]      packet_next;
    logic             out_valid_reg;
    result_t          result_reg;
    result_t          result_next;
    logic             load;

    assign load    = cls_valid && (!out_valid_reg || out_ready);
    assign cls_pop = load;

    always_comb
    begin
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        packet_next = packet_reg;
        result_next = '0;
        case (cls)
            CLS_ZERO:
            begin
                shift_next = {shift_reg[30:0], 1'b0};
                bits_next  = bits_reg - CNT_W'(1);
            end
            CLS_ONE:
            begin
                shift_next = {shift_reg[30:0], 1'b1};
                bits_next  = bits_reg - CNT_W'(1);
            end
            CLS_REPEAT:
            begin
                result_next.repeat_seen = 1'b1;
            end
            CLS_START:
            begin
                if (bits_reg == '0)
                begin
                    packet_next         = shift_reg;
                    result_next.decoded = 1'b1;
                end
                shift_next = '0;
                bits_next  = RELOAD;
            end
            default:
            begin
                shift_next = shift_reg;
            end
        endcase
        result_next.packet = packet_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            bits_reg      <= RELOAD;
            packet_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                shift_reg  <= shift_next;
                bits_reg   <= bits_next;
                packet_reg <= packet_next;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

@@ hdl/nec_ir_pulse_distance_decoder.sv @@
// top level of the nec infrared pulse-distance decoder
// Each item is one receiver edge with its microsecond timestamp; every item gives exactly
// one result item. The front measures the period since the previous edge (modulo 2^32)
// and sorts it into data 0 (1125 us), data 1 (2250 us), repeat (11250 us) or start
// (13500 us), each window nominal plus or minus tolerance_us, first match in that order.
// Classes pass through a two-entry queue to the back, which shifts data bits in, counts
// them down and commits the word on a start that follows PACKET_BITS bits mod 256. The
// block takes one edge per cycle while the queue has room; a result is shown once its
// class has passed the queue register and loaded the result register. The front stalls
// only when the queue is full, which takes a stalled result side. tolerance_us sits at
// byte address 0 and must be written only while the block is idle; no logic checks it.
module nec_ir_pulse_distance_decoder #(
    parameter int unsigned PACKET_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // edge input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [31:0]                    edge_time_us,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           decoded,
    output logic                           repeat_seen,
    output logic [31:0]                    packet_word,
    output logic [7:0]                     address_byte,
    output logic [7:0]                     inverse_address_byte,
    output logic [7:0]                     command_byte,
    output logic [7:0]                     inverse_command_byte,
    output logic                           address_ok,
    output logic                           command_ok,
    output logic                           packet_ok,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [necir_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import necir_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    logic             cfg_write;
    logic             accept;
    class_t           front_cls;
    class_t           back_cls;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;
    result_t          res;

    // configuration register, index taken from the word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TOLERANCE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_write)
        begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TOLERANCE) ? {{(32-TOL_W){1'b0}}, tol_reg} : 32'd0;

    // front accepts whenever the queue has room
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    necir_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .edge_time_us (edge_time_us),
        .tolerance    (tol_reg),
        .cls          (front_cls)
    );

    necir_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_cls  (front_cls),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cls   (back_cls)
    );

    necir_back #(
        .PACKET_BITS (PACKET_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_not_empty),
        .cls       (back_cls),
        .cls_pop   (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (res)
    );

    // byte split and complement checks off the registered packet
    assign decoded              = res.decoded;
    assign repeat_seen          = res.repeat_seen;
    assign packet_word          = res.packet;
    assign address_byte         = res.packet[31:24];
    assign inverse_address_byte = res.packet[23:16];
    assign command_byte         = res.packet[15:8];
    assign inverse_command_byte = res.packet[7:0];
    assign address_ok           = (res.packet[23:16] == ~res.packet[31:24]);
    assign command_ok           = (res.packet[7:0] == ~res.packet[15:8]);
    assign packet_ok            = address_ok && command_ok;

    // a start and a repeat can never be reported by the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(decoded && repeat_seen))
        else $error("decoded and repeat_seen both set");

    // an accepted edge must lead to a valid item on the result side
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 out_valid)
        else $error("accepted edge produced no result");

    // the queue only fills while the result side is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> (out_valid && $past(out_valid && !out_ready)))
        else $error("queue full without output stall");

endmodule

@@ verif/nec_ir_pulse_distance_decoder_tb.sv @@
// self-checking testbench for the nec infrared pulse-distance decoder
`timescale 1ns / 1ps

module nec_ir_pulse_distance_decoder_tb;

    import necir_pkg::*;

    localparam int unsigned PACKET_BITS = 32;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned PHASE_EDGES = 160;
    localparam logic [ADDR_W-1:0] TOL_ADDR = ADDR_W'({REG_TOLERANCE, 2'b00});

    // one decoded result item as the block presents it
    typedef struct packed {
        logic        decoded;
        logic        repeat_seen;
        logic [31:0] packet;
        logic [7:0]  address;
        logic [7:0]  inv_address;
        logic [7:0]  command;
        logic [7:0]  inv_command;
        logic        address_ok;
        logic        command_ok;
        logic        packet_ok;
    } nec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] edge_time_us = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        decoded;
    logic        repeat_seen;
    logic [31:0] packet_word;
    logic [7:0]  address_byte;
    logic [7:0]  inverse_address_byte;
    logic [7:0]  command_byte;
    logic [7:0]  inverse_command_byte;
    logic        address_ok;
    logic        command_ok;
    logic        packet_ok;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    nec_ir_pulse_distance_decoder #(
        .PACKET_BITS(PACKET_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .edge_time_us(edge_time_us),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .decoded(decoded),
        .repeat_seen(repeat_seen),
        .packet_word(packet_word),
        .address_byte(address_byte),
        .inverse_address_byte(inverse_address_byte),
        .command_byte(command_byte),
        .inverse_command_byte(inverse_command_byte),
        .address_ok(address_ok),
        .command_ok(command_ok),
        .packet_ok(packet_ok),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // decoder state as the testbench tracks it
    logic [TOL_W-1:0] model_tol = TOL_RESET;
    logic [31:0]      model_last_stamp = '0;
    logic [31:0]      model_shift = '0;
    logic [CNT_W-1:0] model_bits_left = CNT_W'(PACKET_BITS);
    logic [31:0]      model_packet = '0;

    // edges waiting to be driven, results waiting to be seen
    logic [31:0]  pending_edges [$];
    nec_result_t  expected_results [$];

    // stimulus bookkeeping
    logic [31:0]      gen_stamp = '0;
    int unsigned      phase_items = 0;
    logic [TOL_W-1:0] tol_plan [7];

    // run statistics
    int unsigned edges_sent = 0;
    int unsigned results_checked = 0;
    int unsigned packets_decoded = 0;
    int unsigned repeats_seen = 0;
    int unsigned error_count = 0;
    int unsigned settings_used = 1;

    int unsigned send_gap = 0;
    int unsigned sink_stall = 0;
    bit          send_steady = 1'b0;
    bit          sink_steady = 1'b0;
    int unsigned stall_cycles = 0;
    nec_result_t seen;
    nec_result_t want;

    // inclusive window check around one nominal period
    function automatic bit within_window(input logic [31:0] period, input logic [PER_W-1:0] nom);
        return period >= 32'(nom) - 32'(model_tol) && period <= 32'(nom) + 32'(model_tol);
    endfunction

    // next result of the decoder for an edge at stamp_now, updating the tracked state
    function automatic nec_result_t decode_edge(input logic [31:0] stamp_now);
        logic [31:0] period;
        class_t      kind;
        nec_result_t r;
        period = stamp_now - model_last_stamp;
        model_last_stamp = stamp_now;
        // fixed priority: the first window that matches wins when windows overlap
        if (within_window(period, NOM_ZERO))
            kind = CLS_ZERO;
        else if (within_window(period, NOM_ONE))
            kind = CLS_ONE;
        else if (within_window(period, NOM_REPEAT))
            kind = CLS_REPEAT;
        else if (within_window(period, NOM_START))
            kind = CLS_START;
        else
            kind = CLS_NONE;
        r.decoded = 1'b0;
        r.repeat_seen = 1'b0;
        case (kind)
            CLS_ZERO:
            begin
                model_bits_left = model_bits_left - 1'b1;
                model_shift = {model_shift[30:0], 1'b0};
            end
            CLS_ONE:
            begin
                model_bits_left = model_bits_left - 1'b1;
                model_shift = {model_shift[30:0], 1'b1};
            end
            CLS_REPEAT:
                r.repeat_seen = 1'b1;
            CLS_START:
            begin
                // commit only after exactly a packet's worth of bits (count wraps mod 256)
                if (model_bits_left == '0)
                begin
                    model_packet = model_shift;
                    r.decoded = 1'b1;
                end
                model_shift = '0;
                model_bits_left = CNT_W'(PACKET_BITS);
            end
            default:
                ;
        endcase
        r.packet = model_packet;
        r.address = model_packet[31:24];
        r.inv_address = model_packet[23:16];
        r.command = model_packet[15:8];
        r.inv_command = model_packet[7:0];
        r.address_ok = (r.inv_address == ~r.address);
        r.command_ok = (r.inv_command == ~r.command);
        r.packet_ok = r.address_ok & r.command_ok;
        return r;
    endfunction

    function automatic string fmt_result(input nec_result_t v);
        return $sformatf("dec=%0b rep=%0b pkt=%h bytes=%h/%h/%h/%h ok=%0b%0b%0b",
                         v.decoded, v.repeat_seen, v.packet, v.address, v.inv_address,
                         v.command, v.inv_command, v.address_ok, v.command_ok, v.packet_ok);
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // mostly back-to-back, now and then a short gap, rarely a long one
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // edge driver: presents queued edges, predicts on each acceptance
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            edge_time_us <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(decode_edge(edge_time_us));
                edges_sent++;
            end
            // the slot frees up when nothing is shown or the shown item is taken
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_edges.size() != 0)
                begin
                    in_valid <= 1'b1;
                    edge_time_us <= pending_edges.pop_front();
                    send_gap <= pick_gap(send_steady);
                end
                else
                    in_valid <= 1'b0;
            end
            // switch between gappy traffic and gap-free stretches now and then
            if ($urandom_range(0, 149) == 0)
                send_steady <= !send_steady;
        end
    end

    // ---------------------------------------------------------------
    // result monitor: random back-pressure, in-order compare
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {decoded, repeat_seen, packet_word, address_byte, inverse_address_byte,
                        command_byte, inverse_command_byte, address_ok, command_ok, packet_ok};
                if (expected_results.size() == 0)
                    flag_error($sformatf("result with nothing expected: %s", fmt_result(seen)));
                else
                begin
                    want = expected_results.pop_front();
                    if (seen !== want)
                        flag_error($sformatf("result %0d mismatch: expected %s, got %s",
                                             results_checked, fmt_result(want),
                                             fmt_result(seen)));
                    packets_decoded += want.decoded;
                    repeats_seen += want.repeat_seen;
                end
                results_checked++;
            end
            if (sink_stall != 0)
            begin
                sink_stall <= sink_stall - 1;
                out_ready <= 1'b0;
            end
            else if (!sink_steady && $urandom_range(0, 3) == 0)
            begin
                sink_stall <= pick_gap(1'b0);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
            if ($urandom_range(0, 149) == 0)
                sink_steady <= !sink_steady;
        end
    end

    // watchdog: too long without any item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_period(input logic [31:0] period);
        gen_stamp = gen_stamp + period;
        pending_edges.push_back(gen_stamp);
        phase_items++;
    endtask

    task automatic push_stamp(input logic [31:0] stamp_abs);
        gen_stamp = stamp_abs;
        pending_edges.push_back(gen_stamp);
        phase_items++;
    endtask

    // a period inside the current window, often right on an edge of it
    function automatic logic [31:0] near(input logic [PER_W-1:0] nom);
        int spread;
        int offset;
        int unsigned r;
        spread = int'(model_tol);
        r = $urandom_range(0, 7);
        if (r == 0)
            offset = -spread;
        else if (r == 1)
            offset = spread;
        else
            offset = int'($urandom_range(0, 2 * spread)) - spread;
        return 32'(int'(nom) + offset);
    endfunction

    // data bits msb first; past 32 bits the extra bits are random
    task automatic send_bits(input logic [31:0] word, input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if ((i < 32) ? word[31 - i] : 1'($urandom_range(0, 1)))
                push_period(near(NOM_ONE));
            else
                push_period(near(NOM_ZERO));
        end
    endtask

    // mostly proper address/command pairs, some random or one bit broken
    function automatic logic [31:0] frame_word();
        logic [7:0]  a;
        logic [7:0]  c;
        logic [31:0] w;
        int unsigned r;
        a = 8'($urandom);
        c = 8'($urandom);
        w = {a, ~a, c, ~c};
        r = $urandom_range(0, 19);
        if (r < 3)
            w = $urandom;
        else if (r < 6)
            w[5'($urandom_range(0, 31))] ^= 1'b1;
        return w;
    endfunction

    // something that should fall outside every window, or at least be odd
    task automatic send_noise();
        int unsigned      r;
        logic [PER_W-1:0] nom;
        r = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0: nom = NOM_ZERO;
            1: nom = NOM_ONE;
            2: nom = NOM_REPEAT;
            default: nom = NOM_START;
        endcase
        if (r == 0)
            push_period($urandom);
        else if (r == 1)
            push_period(32'(nom) + 32'(model_tol) + 32'd1);
        else if (r == 2)
            push_period(32'(nom) - 32'(model_tol) - 32'd1);
        else
            push_period($urandom_range(0, 20000));
    endtask

    // one phase of random traffic, mostly well-formed frames
    task automatic fill_phase(input bit with_long_frame);
        int unsigned pick;
        int unsigned n;
        phase_items = 0;
        if (with_long_frame)
        begin
            // 288 bits bring the count round to zero again, so the next start commits
            push_period(near(NOM_START));
            send_bits(frame_word(), 288);
        end
        while (phase_items < PHASE_EDGES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
            begin
                push_period(near(NOM_START));
                send_bits(frame_word(), 32);
                n = $urandom_range(0, 3);
                repeat (n) push_period(near(NOM_REPEAT));
            end
            else if (pick < 74)
            begin
                // frame with the wrong bit count: start clears without a commit
                push_period(near(NOM_START));
                n = $urandom_range(0, 40);
                if (n == 32)
                    n = 33;
                send_bits($urandom, n);
            end
            else if (pick < 82)
            begin
                n = $urandom_range(1, 4);
                repeat (n) push_period(near(NOM_REPEAT));
            end
            else if (pick < 92)
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_noise();
            end
            else
            begin
                // frame interrupted by a stray edge
                push_period(near(NOM_START));
                send_bits($urandom, $urandom_range(1, 31));
                send_noise();
                send_bits($urandom, $urandom_range(0, 8));
            end
        end
        // closing start commits the last full frame
        push_period(near(NOM_START));
    endtask

    // wait until every queued edge has gone through and every result has come back
    task automatic drain();
        while (pending_edges.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TOL_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        // register takes the value at this edge
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_tol = value;
        settings_used++;
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial
    begin
        tol_plan[0] = '0;
        tol_plan[1] = 10'd1023;
        tol_plan[2] = 10'd1000;
        tol_plan[3] = 10'd562;
        tol_plan[4] = 10'd563;
        tol_plan[5] = 10'($urandom_range(0, 1000));
        tol_plan[6] = 10'($urandom_range(0, 1000));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed edges at the reset tolerance
        push_stamp(32'h0000_0000);            // zero period before any packet
        push_stamp(32'hFFFF_FFFF);            // largest stamp, unclassified
        push_period(32'(NOM_START));          // wraps the stamp past zero
        push_period(32'(NOM_ZERO) - 32'(model_tol));    // window edges, inclusive
        push_period(32'(NOM_ZERO) + 32'(model_tol));
        push_period(32'(NOM_ONE) - 32'(model_tol));
        push_period(32'(NOM_ONE) + 32'(model_tol));
        push_period(32'(NOM_ZERO) - 32'(model_tol) - 32'd1); // just outside
        push_period(32'(NOM_ONE) + 32'(model_tol) + 32'd1);
        push_period(32'(NOM_REPEAT) - 32'(model_tol));
        push_period(32'(NOM_REPEAT) + 32'(model_tol));
        push_period(32'(NOM_REPEAT) - 32'(model_tol) - 32'd1);
        push_period(32'(NOM_START) - 32'(model_tol));   // start after 4 bits: no commit
        push_period(32'(NOM_START) + 32'(model_tol) + 32'd1);
        push_stamp(32'hFFFF_F000);
        push_period(32'(NOM_START) + 32'(model_tol));   // start across the wrap
        send_bits(32'hA55A_0FF0, 4);
        fill_phase(1'b0);
        drain();

        for (int p = 0; p < 7; p++)
        begin
            write_tolerance(tol_plan[p]);
            if (tol_plan[p] >= 10'd563)
            begin
                // overlapping data windows: the data-0 window must win
                push_period(32'd1700);
                push_period(32'd1200);
                push_period(32'(NOM_ONE) - 32'(model_tol));
            end
            fill_phase(p == 0);
            drain();
        end
        write_tolerance(TOL_RESET);
        fill_phase(1'b0);
        drain();
        repeat (8) @(posedge clk);

        if (expected_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_results.size()));
        $display("covered %0d edges over %0d tolerance settings, %0d results checked",
                 edges_sent, settings_used, results_checked);
        $display("%0d packets decoded, %0d repeat codes, %0d mismatches",
                 packets_decoded, repeats_seen, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ nec_ir_pulse_distance_decoder.f @@
hdl/necir_pkg.sv
hdl/necir_front.sv
hdl/necir_fifo.sv
hdl/necir_back.sv
hdl/nec_ir_pulse_distance_decoder.sv
verif/nec_ir_pulse_distance_decoder_tb.sv
